// File: hdl/tcs_pkg.sv
// Shared types and constants for the tick-count to 100 ns scaler.
// No dependencies; imported by every module of the block.
package tcs_pkg;

  // Ticks are scaled by this factor before division by the counter frequency
  localparam int unsigned ScaleW = 24;
  localparam logic [ScaleW-1:0] SCALE_100NS = 24'd10000000;

  // Configuration register indexes
  localparam int unsigned CfgAddrW = 2;
  localparam logic [CfgAddrW-1:0] REG_SHIFT_COUNT = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_NORM_DIVISOR = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_RECIPROCAL = 2'd2;

  localparam int unsigned ShiftW = 6;
  localparam int unsigned WordW = 64;

  // One result item
  typedef struct packed {
    logic [WordW-1:0] time_100ns;
    logic             overflow;
  } result_t;

endpackage

// File: hdl/tcs_mul64.sv
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
// Depends on tcs_pkg for the word width.
module tcs_mul64 (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [tcs_pkg::WordW-1:0]      a_i,
  input  logic [tcs_pkg::WordW-1:0]      b_i,
  output logic [2*tcs_pkg::WordW-1:0]    prod_o
);
  import tcs_pkg::*;

  localparam int unsigned HalfW = WordW / 2;

  logic [WordW-1:0]   pp00_q, pp01_q, pp10_q, pp11_q;
  logic [2*WordW-1:0] prod_q, prod_d;

  // Form the partial products of the 32-bit halves
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp00_q <= WordW'(a_i[HalfW-1:0])     * WordW'(b_i[HalfW-1:0]);
      pp01_q <= WordW'(a_i[HalfW-1:0])     * WordW'(b_i[WordW-1:HalfW]);
      pp10_q <= WordW'(a_i[WordW-1:HalfW]) * WordW'(b_i[HalfW-1:0]);
      pp11_q <= WordW'(a_i[WordW-1:HalfW]) * WordW'(b_i[WordW-1:HalfW]);
    end
  end

  // Align and sum the partial products
  always_comb begin
    prod_d = {{WordW{1'b0}}, pp00_q}
           + {{HalfW{1'b0}}, pp01_q, {HalfW{1'b0}}}
           + {{HalfW{1'b0}}, pp10_q, {HalfW{1'b0}}}
           + {pp11_q, {WordW{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: hdl/tcs_out_buf.sv
// Output register with one skid entry; decouples the pipeline from out_stall.
// Depends on tcs_pkg for the result item type.
module tcs_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pipe_valid_i,
  input  tcs_pkg::result_t pipe_data_i,
  output logic             pipe_en_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tcs_pkg::result_t out_data_o
);
  import tcs_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;
  logic    pop;

  assign pop       = out_valid_q && !out_stall_i;
  assign pipe_en_o = !skid_valid_q;

  // Refill the output register from the skid entry first, then the pipeline
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_d = pipe_valid_i;
      out_data_d  = pipe_data_i;
    end else if (pipe_valid_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = pipe_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: hdl/tick_count_to_100ns_scaler_core.sv
// Top level of the tick-count to 100 ns scaler: pipeline, configuration registers.
// Depends on tcs_pkg, tcs_mul64 and tcs_out_buf.
//
//   channel | signals                                  | direction
//   input   | in_valid_i, in_stall_o, tick_count_i     | in
//   output  | out_valid_o, out_stall_i, time_100ns_o,  | out
//           | overflow_o                               |
//   config  | cfg_we_i, cfg_addr_i, cfg_data_i         | in
//
// One item per cycle while in_stall_o is low; each item passes the pipeline stages and
// then the output register, with the two 64x64 multiplies each split over two stages.
// Reset clears the valid bits and loads shift 0, divisor 2^63, reciprocal all ones.
// A stalled result sits in the output register; one more result lands in a skid
// entry, and only while that entry is full does in_stall_o rise and the pipe freeze.
module tick_count_to_100ns_scaler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcs_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [tcs_pkg::WordW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tcs_pkg::WordW-1:0]     tick_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tcs_pkg::WordW-1:0]     time_100ns_o,
  output logic                          overflow_o
);
  import tcs_pkg::*;

  localparam int unsigned HalfW = WordW / 2;
  localparam int unsigned PpW   = HalfW + ScaleW;
  localparam int unsigned ProdW = WordW + ScaleW;

  logic en;

  // Configuration registers
  logic [ShiftW-1:0] shift_q;
  logic [WordW-1:0]  div_q, recip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      div_q   <= {1'b1, {(WordW-1){1'b0}}};
      recip_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SHIFT_COUNT:  shift_q <= cfg_data_i[ShiftW-1:0];
        REG_NORM_DIVISOR: div_q   <= cfg_data_i;
        REG_RECIPROCAL:   recip_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits of stages 1..10
  localparam int unsigned NStg = 10;
  logic [NStg:1] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NStg-1:1], in_valid_i};
    end
  end

  assign in_stall_o = !en;

  // Stage 1: scale both halves of the tick count
  logic [PpW-1:0] s1_lo_q, s1_hi_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_lo_q <= PpW'(tick_count_i[HalfW-1:0]) * PpW'(SCALE_100NS);
      s1_hi_q <= PpW'(tick_count_i[WordW-1:HalfW]) * PpW'(SCALE_100NS);
    end
  end

  // Stage 2: combine into the scaled product
  logic [ProdW-1:0] s2_prod_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_prod_q <= {{(ProdW-PpW){1'b0}}, s1_lo_q}
                 + {s1_hi_q, {HalfW{1'b0}}};
    end
  end

  // Stage 3: normalize the dividend, catch bits shifted past the top
  logic [3*WordW-1:0] wide;
  logic [WordW-1:0]   s3_n2_q, s3_n10_q;
  logic               s3_lost_q;
  assign wide = {{(3*WordW-ProdW){1'b0}}, s2_prod_q} << shift_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_n2_q   <= wide[2*WordW-1:WordW];
      s3_n10_q  <= wide[WordW-1:0];
      s3_lost_q <= |wide[3*WordW-1:2*WordW];
    end
  end

  // Stage 4: adjust by the top bit of the low word
  logic [WordW-1:0] m4;
  logic [WordW:0]   a0_sum;
  logic [WordW-1:0] s4_u_q, s4_a0_q, s4_a1_q, s4_n2_q, s4_n10_q;
  logic             s4_ovf_q;
  assign m4     = {WordW{s3_n10_q[WordW-1]}};
  assign a0_sum = {1'b0, s3_n10_q} + {1'b0, m4 & div_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_u_q   <= s3_n2_q - m4;
      s4_a0_q  <= a0_sum[WordW-1:0];
      s4_a1_q  <= m4 + {{(WordW-1){1'b0}}, a0_sum[WordW]};
      s4_n2_q  <= s3_n2_q;
      s4_n10_q <= s3_n10_q;
      s4_ovf_q <= s3_lost_q || (s3_n2_q >= div_q);
    end
  end

  // Stages 5-6: estimate product reciprocal * (n2 - m)
  logic [2*WordW-1:0] est_prod;
  tcs_mul64 u_mul_est (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (recip_q),
    .b_i    (s4_u_q),
    .prod_o (est_prod)
  );

  logic [WordW-1:0] s5_a0_q, s5_a1_q, s5_n2_q, s5_n10_q;
  logic [WordW-1:0] s6_a0_q, s6_a1_q, s6_n2_q, s6_n10_q;
  logic             s5_ovf_q, s6_ovf_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_a0_q  <= s4_a0_q;
      s5_a1_q  <= s4_a1_q;
      s5_n2_q  <= s4_n2_q;
      s5_n10_q <= s4_n10_q;
      s5_ovf_q <= s4_ovf_q;
      s6_a0_q  <= s5_a0_q;
      s6_a1_q  <= s5_a1_q;
      s6_n2_q  <= s5_n2_q;
      s6_n10_q <= s5_n10_q;
      s6_ovf_q <= s5_ovf_q;
    end
  end

  // Stage 7: form the quotient estimate q1
  logic [WordW:0]   lo_sum;
  logic [WordW-1:0] s7_q1_q, s7_n2_q, s7_n10_q;
  logic             s7_ovf_q;
  assign lo_sum = {1'b0, est_prod[WordW-1:0]} + {1'b0, s6_a0_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_q1_q  <= est_prod[2*WordW-1:WordW] + s6_a1_q + s6_n2_q
                + {{(WordW-1){1'b0}}, lo_sum[WordW]};
      s7_n2_q  <= s6_n2_q;
      s7_n10_q <= s6_n10_q;
      s7_ovf_q <= s6_ovf_q;
    end
  end

  // Stages 8-9: correction product ~q1 * d
  logic [2*WordW-1:0] cor_prod;
  tcs_mul64 u_mul_cor (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (~s7_q1_q),
    .b_i    (div_q),
    .prod_o (cor_prod)
  );

  logic [WordW-1:0] s8_q1_q, s8_n2_q, s8_n10_q;
  logic [WordW-1:0] s9_q1_q, s9_n2_q, s9_n10_q;
  logic             s8_ovf_q, s9_ovf_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_q1_q  <= s7_q1_q;
      s8_n2_q  <= s7_n2_q;
      s8_n10_q <= s7_n10_q;
      s8_ovf_q <= s7_ovf_q;
      s9_q1_q  <= s8_q1_q;
      s9_n2_q  <= s8_n2_q;
      s9_n10_q <= s8_n10_q;
      s9_ovf_q <= s8_ovf_q;
    end
  end

  // Stage 10: remainder high word plus one plus q1, split into two addends
  logic [WordW:0]   dl_sum;
  logic [WordW-1:0] s10_x_q, s10_y_q;
  logic             s10_ovf_q;
  assign dl_sum = {1'b0, cor_prod[WordW-1:0]} + {1'b0, s9_n10_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      s10_x_q   <= cor_prod[2*WordW-1:WordW] + ~div_q + WordW'(2)
                 + {{(WordW-1){1'b0}}, dl_sum[WordW]};
      s10_y_q   <= s9_n2_q + s9_q1_q;
      s10_ovf_q <= s9_ovf_q;
    end
  end

  // Final sum and saturation
  result_t res;
  always_comb begin
    res.overflow   = s10_ovf_q;
    res.time_100ns = s10_ovf_q ? {WordW{1'b1}} : (s10_x_q + s10_y_q);
  end

  result_t out_data;
  tcs_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pipe_valid_i (v_q[NStg]),
    .pipe_data_i  (res),
    .pipe_en_o    (en),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data)
  );

  assign time_100ns_o = out_data.time_100ns;
  assign overflow_o   = out_data.overflow;

endmodule

// File: hdl/tcs_checker.sv
// Port-level checks for the tick-count to 100 ns scaler, bound to the top level.
// Depends on tcs_pkg for widths and on tick_count_to_100ns_scaler_core for the bind.
module tcs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [tcs_pkg::WordW-1:0]     time_100ns_o,
  input logic                          overflow_o
);
  import tcs_pkg::*;

  // Hold a stalled result item unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(time_100ns_o) && $stable(overflow_o))
    else $error("stalled result item changed or dropped");

  // Saturate the quotient whenever overflow is flagged
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> time_100ns_o == {WordW{1'b1}})
    else $error("overflow without saturated quotient");

  // Back-pressure input only after an output stall
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output stall");

  // Keep the input open while no result waits
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

endmodule

bind tick_count_to_100ns_scaler_core tcs_checker u_tcs_checker (.*);
